// ===== rtl/skset_pkg.sv =====
// Shared types, sizes and codes of the sorted key set.
`default_nettype none

package skset_pkg;

  localparam int CAPACITY = 256;
  localparam int KEY_W    = 32;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int ENTRY_W  = 9;

  typedef logic        [1:0]       req_type_t;
  typedef logic signed [KEY_W-1:0] key_t;
  typedef logic        [1:0]       status_t;
  typedef logic        [ENTRY_W-1:0] entry_count_t;

  localparam req_type_t REQ_ADD    = 2'd0;
  localparam req_type_t REQ_REMOVE = 2'd1;
  localparam req_type_t REQ_TEST   = 2'd2;
  localparam req_type_t REQ_CLEAR  = 2'd3;

  localparam status_t ST_FALSE = 2'd0;
  localparam status_t ST_TRUE  = 2'd1;
  localparam status_t ST_FULL  = 2'd2;

  localparam key_t KEY_LOW_SENTINEL  = 32'sh8000_0000;
  localparam key_t KEY_HIGH_SENTINEL = 32'sh7FFF_FFFF;

  // controller to datapath
  typedef struct packed {
    logic capture;  // latch request and compare against every cell
    logic exec;     // shift cells, update count, load result register
  } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/skset_if.sv =====
// Request and response channel interfaces of the sorted key set.
`default_nettype none

interface skset_req_if import skset_pkg::*;;
  logic      valid;
  logic      ready;
  req_type_t req_type;
  key_t      key;

  modport source (output valid, output req_type, output key, input ready);
  modport sink   (input valid, input req_type, input key, output ready);
endinterface

interface skset_rsp_if import skset_pkg::*;;
  logic         valid;
  logic         ready;
  status_t      status;
  entry_count_t entry_count;

  modport source (output valid, output status, output entry_count, input ready);
  modport sink   (input valid, input status, input entry_count, output ready);
endinterface

`default_nettype wire

// ===== rtl/skset_ctrl.sv =====
// Controller: request handshake, compare/execute sequencing and response valid.
`default_nettype none

module skset_ctrl import skset_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output cmd_t cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state;
  logic state_next;
  logic slot_free;

  assign in_ready    = (state == S_IDLE);
  assign slot_free   = !out_valid || out_ready;
  assign cmd.capture = in_valid && in_ready;
  assign cmd.exec    = (state == S_EXEC) && slot_free;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (cmd.capture) state_next = S_EXEC;
      S_EXEC: if (cmd.exec) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.exec) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // a new result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |-> (!out_valid || out_ready))
    else $error("result register overwritten");

  a_capture_to_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> (state == S_EXEC))
    else $error("captured word not followed by execute");

  a_exec_gives_word: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |=> out_valid)
    else $error("execute did not present a response word");

endmodule

`default_nettype wire

// ===== rtl/skset_dp.sv =====
// Datapath: row of key cells with per-cell comparators, count and result register.
`default_nettype none

module skset_dp import skset_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  cmd_t         cmd,
  input  req_type_t    in_req_type,
  input  key_t         in_key,
  output status_t      status,
  output entry_count_t entry_count
);

  key_t                cells [CAPACITY];
  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    count_next;
  req_type_t           req_q;
  key_t                key_q;
  logic [CAPACITY-1:0] ge_q;   // cell at or above the insertion point
  logic [CAPACITY-1:0] eq_q;   // valid cell holding the key
  logic                found;
  logic                sentinel;
  logic                full;
  logic                do_ins;
  logic                do_rem;
  status_t             status_next;

  // per-cell compare; cells at or beyond the count sort as above every key
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_q <= in_req_type;
      key_q <= in_key;
      for (int i = 0; i < CAPACITY; i++) begin
        ge_q[i] <= (CNT_W'(i) >= count) || (cells[i] >= in_key);
        eq_q[i] <= (CNT_W'(i) < count) && (cells[i] == in_key);
      end
    end
  end

  assign found    = |eq_q;
  assign sentinel = (key_q == KEY_LOW_SENTINEL) || (key_q == KEY_HIGH_SENTINEL);
  assign full     = (count == CNT_W'(CAPACITY));

  always_comb begin
    status_next = ST_FALSE;
    count_next  = count;
    do_ins      = 1'b0;
    do_rem      = 1'b0;
    case (req_q)
      REQ_ADD: begin
        if (!sentinel && !found) begin
          if (full) begin
            status_next = ST_FULL;
          end else begin
            do_ins      = 1'b1;
            count_next  = count + CNT_W'(1);
            status_next = ST_TRUE;
          end
        end
      end
      REQ_REMOVE: begin
        if (!sentinel && found) begin
          do_rem      = 1'b1;
          count_next  = count - CNT_W'(1);
          status_next = ST_TRUE;
        end
      end
      REQ_TEST: begin
        if (!sentinel && found) status_next = ST_TRUE;
      end
      REQ_CLEAR: begin
        count_next  = '0;
        status_next = ST_TRUE;
      end
      default: status_next = ST_FALSE;
    endcase
  end

  // insert shifts the upper part up by one, remove pulls it down by one
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    always_ff @(posedge clk) begin
      if (cmd.exec && do_ins && ge_q[i]) begin
        if (i == 0) begin
          cells[i] <= key_q;
        end else begin
          cells[i] <= ge_q[(i > 0) ? i - 1 : 0] ? cells[(i > 0) ? i - 1 : 0] : key_q;
        end
      end else if (cmd.exec && do_rem && ge_q[i] && (i < CAPACITY - 1)) begin
        cells[i] <= cells[(i < CAPACITY - 1) ? i + 1 : i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.exec) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status      <= status_next;
      entry_count <= ENTRY_W'(count_next);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("count above capacity");

  // held keys are distinct, so at most one cell can match
  a_single_match: assert property (@(posedge clk) disable iff (rst)
    $past(cmd.capture) && !$past(rst) |-> $onehot0(eq_q))
    else $error("more than one cell matches the key");

  // compare flags must form one step: once set, set in every higher cell
  a_ge_step: assert property (@(posedge clk) disable iff (rst)
    $past(cmd.capture) && !$past(rst) |-> ((ge_q << 1) & ~ge_q) == '0)
    else $error("cell order broken");

endmodule

`default_nettype wire

// ===== rtl/sorted_key_set.sv =====
// Top level of the sorted key set: controller, datapath and channel ports.
`default_nettype none

// Holds up to 256 distinct signed 32-bit keys in ascending order in a row of
// cells. A request word adds, removes, tests or clears, and each gives one
// response word with a status and the count held afterwards. A request has an
// accept step, in which the key is compared against every cell in parallel,
// and an execute step, in which the cells shift by one place (or hold) and the
// response is registered. The execute step waits while an earlier response
// word has not been taken; a new request is accepted as soon as it is done.
// Reset clears the count, state and output valid; the cells need no clearing.
module sorted_key_set import skset_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  skset_req_if.sink          req,
  skset_rsp_if.source        rsp
);

  cmd_t cmd;

  skset_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (cmd)
  );

  skset_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .in_req_type (req.req_type),
    .in_key      (req.key),
    .status      (rsp.status),
    .entry_count (rsp.entry_count)
  );

endmodule

`default_nettype wire

// ===== tb/sorted_key_set_test.sv =====
// Testbench of the sorted key set: directed, fill and random request streams checked by a predictor.
`timescale 1ns / 100ps

module sorted_key_set_test;
  import skset_pkg::*;

  localparam int STALL_PCT   = 13;
  localparam int STALL_LIMIT = 1000;
  localparam int MAX_REPORTS = 10;

  typedef struct {
    req_type_t    op;
    key_t         key;
    status_t      status;
    entry_count_t entry_count;
  } outcome_t;

  logic clk;
  logic rst;

  skset_req_if req_ch();
  skset_rsp_if rsp_ch();

  sorted_key_set i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  key_t     held_keys[$];
  outcome_t pending_outcomes[$];
  key_t     key_pool[$];

  bit steady_flow;
  int mismatches;
  int words_sent;
  int words_checked;
  int idle_cycles;
  int op_counts[4];
  int full_refusals;

  always #5 clk = ~clk;

  // Sorted-set predictor: updates held_keys and gives the response status.
  function automatic status_t apply_to_set(input req_type_t op, input key_t k);
    int pos;
    bit found;
    status_t st;
    st = ST_FALSE;
    if (op == REQ_CLEAR) begin
      held_keys.delete();
      st = ST_TRUE;
    end else if (k != KEY_LOW_SENTINEL && k != KEY_HIGH_SENTINEL) begin
      pos = 0;
      while (pos < held_keys.size() && held_keys[pos] < k) pos++;
      found = (pos < held_keys.size()) && (held_keys[pos] == k);
      case (op)
        REQ_ADD: begin
          if (found) begin
            st = ST_FALSE;
          end else if (held_keys.size() >= CAPACITY) begin
            st = ST_FULL;
          end else begin
            held_keys.insert(pos, k);
            st = ST_TRUE;
          end
        end
        REQ_REMOVE: begin
          if (found) begin
            held_keys.delete(pos);
            st = ST_TRUE;
          end
        end
        default: begin
          st = found ? ST_TRUE : ST_FALSE;
        end
      endcase
    end
    return st;
  endfunction

  // Drives one request word from a falling edge and returns at the accepting rising edge.
  task automatic send_request(input req_type_t op, input key_t k);
    outcome_t o;
    @(negedge clk);
    while (!steady_flow && $urandom_range(99) < STALL_PCT) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= op;
    req_ch.key      <= k;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    o.op          = op;
    o.key         = k;
    o.status      = apply_to_set(op, k);
    o.entry_count = entry_count_t'(held_keys.size());
    if (o.status == ST_FULL) full_refusals++;
    op_counts[op]++;
    words_sent++;
    pending_outcomes.push_back(o);
  endtask

  function automatic key_t random_key();
    return key_t'($urandom);
  endfunction

  task automatic test_directed();
    send_request(REQ_TEST, 32'sd0);
    send_request(REQ_REMOVE, 32'sd0);
    send_request(REQ_ADD, -32'sd2147483647);
    send_request(REQ_ADD, 32'sd2147483646);
    send_request(REQ_ADD, 32'sd0);
    send_request(REQ_ADD, 32'sd0);
    send_request(REQ_ADD, -32'sd1);
    send_request(REQ_TEST, 32'sd0);
    send_request(REQ_TEST, 32'sd5);
    send_request(REQ_TEST, -32'sd2147483647);
    send_request(REQ_TEST, 32'sd2147483646);
    send_request(REQ_ADD, KEY_LOW_SENTINEL);
    send_request(REQ_ADD, KEY_HIGH_SENTINEL);
    send_request(REQ_TEST, KEY_LOW_SENTINEL);
    send_request(REQ_TEST, KEY_HIGH_SENTINEL);
    send_request(REQ_REMOVE, KEY_LOW_SENTINEL);
    send_request(REQ_REMOVE, KEY_HIGH_SENTINEL);
    send_request(REQ_REMOVE, 32'sd0);
    send_request(REQ_REMOVE, 32'sd0);
    send_request(REQ_REMOVE, 32'sd77);
    send_request(REQ_CLEAR, 32'sd12345);
    send_request(REQ_TEST, -32'sd1);
    send_request(REQ_CLEAR, KEY_HIGH_SENTINEL);
  endtask

  // Fills the set with no idling on either side, probes the full set, then frees a slot, refills and clears.
  task automatic test_fill_to_capacity();
    steady_flow = 1'b1;
    while (held_keys.size() < CAPACITY) send_request(REQ_ADD, random_key());
    send_request(REQ_ADD, random_key());
    send_request(REQ_ADD, held_keys[10]);
    send_request(REQ_ADD, KEY_HIGH_SENTINEL);
    send_request(REQ_TEST, held_keys[0]);
    send_request(REQ_TEST, held_keys[CAPACITY-1]);
    steady_flow = 1'b0;
    send_request(REQ_REMOVE, held_keys[CAPACITY-1]);
    send_request(REQ_ADD, random_key());
    send_request(REQ_ADD, random_key());
    send_request(REQ_CLEAR, random_key());
  endtask

  // Small key pool so that hits, duplicates and misses all come often.
  task automatic test_random_mixed(input int n_words);
    int r;
    key_t k;
    req_type_t op;
    key_pool.delete();
    repeat (40) key_pool.push_back(random_key());
    repeat (n_words) begin
      r = $urandom_range(99);
      if (r < 8) k = random_key();
      else if (r < 10) k = r[0] ? KEY_LOW_SENTINEL : KEY_HIGH_SENTINEL;
      else k = key_pool[$urandom_range(key_pool.size()-1)];
      r = $urandom_range(99);
      if (r < 40) op = REQ_ADD;
      else if (r < 66) op = REQ_REMOVE;
      else if (r < 98) op = REQ_TEST;
      else op = REQ_CLEAR;
      send_request(op, k);
    end
  endtask

  // Adds and removes around the capacity limit so the full case recurs.
  task automatic test_churn_near_full(input int n_words);
    int r;
    while (held_keys.size() < CAPACITY - 3) send_request(REQ_ADD, random_key());
    repeat (n_words) begin
      r = $urandom_range(99);
      if (r < 45) send_request(REQ_ADD, random_key());
      else if (r < 55) send_request(REQ_ADD, held_keys[$urandom_range(held_keys.size()-1)]);
      else if (r < 75) send_request(REQ_REMOVE, held_keys[$urandom_range(held_keys.size()-1)]);
      else if (r < 80) send_request(REQ_REMOVE, random_key());
      else if (r < 92) send_request(REQ_TEST, held_keys[$urandom_range(held_keys.size()-1)]);
      else send_request(REQ_TEST, random_key());
    end
    send_request(REQ_CLEAR, random_key());
  endtask

  // response checker
  always @(posedge clk) begin
    outcome_t o;
    if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      words_checked++;
      if (pending_outcomes.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected response word status=%0d count=%0d",
                   $realtime, rsp_ch.status, rsp_ch.entry_count);
      end else begin
        o = pending_outcomes.pop_front();
        if (rsp_ch.status !== o.status || rsp_ch.entry_count !== o.entry_count) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: op %0d key %0d: expected status=%0d count=%0d, got status=%0d count=%0d",
                     $realtime, o.op, o.key, o.status, o.entry_count,
                     rsp_ch.status, rsp_ch.entry_count);
        end
      end
    end
  end

  always @(negedge clk) begin
    rsp_ch.ready <= steady_flow || ($urandom_range(99) >= STALL_PCT);
  end

  always @(posedge clk) begin
    if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
        (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < STALL_LIMIT) @(posedge clk);
    $display("Timed out after %0d cycles with nothing accepted", STALL_LIMIT);
    $display("FAIL");
    $finish;
  end

  initial begin
    clk             = 1'b0;
    rst             = 1'b1;
    idle_cycles     = 0;
    steady_flow     = 1'b0;
    req_ch.valid    = 1'b0;
    req_ch.req_type = REQ_TEST;
    req_ch.key      = '0;
    rsp_ch.ready    = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_fill_to_capacity();
    test_random_mixed(1000);
    test_churn_near_full(300);

    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d request words (add %0d, remove %0d, test %0d, clear %0d), checked %0d",
             words_sent, op_counts[REQ_ADD], op_counts[REQ_REMOVE], op_counts[REQ_TEST],
             op_counts[REQ_CLEAR], words_checked);
    $display("Adds refused on a full set: %0d; mismatches: %0d", full_refusals, mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== sorted_key_set.f =====
rtl/skset_pkg.sv
rtl/skset_if.sv
rtl/skset_ctrl.sv
rtl/skset_dp.sv
rtl/sorted_key_set.sv
tb/sorted_key_set_test.sv
